// ===== src/jhs_pkg.sv =====
// shared types, codes and helpers for the jfif header scanner
// no dependencies; imported by every module of the block
package jhs_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int DIM_W    = 16;
    localparam int STAGE_W  = 2;
    localparam int PHASE_W  = 3;
    localparam int INDEX_W  = 3;
    localparam int SOF_W    = 48;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SOI    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_APP0  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SOF   = 3'd4;

    // parse stages
    localparam logic [STAGE_W-1:0] STAGE_SOI  = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_APP0 = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_SCAN = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_SOF  = 2'd3;

    // field phases within a segment
    localparam logic [PHASE_W-1:0] PH_MARK_HI = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MARK_LO = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

    localparam logic [15:0] MARKER_SOI  = 16'hFFD8;
    localparam logic [15:0] MARKER_EOI  = 16'hFFD9;
    localparam logic [15:0] MARKER_APP0 = 16'hFFE0;
    localparam logic [15:0] MARKER_TEM  = 16'hFF01;
    localparam logic [15:0] MARKER_DHT  = 16'hFFC4;
    localparam logic [15:0] MARKER_JPG  = 16'hFFC8;
    localparam logic [15:0] MARKER_DAC  = 16'hFFCC;
    localparam logic [15:0] RST_MASK    = 16'hFFF8;
    localparam logic [15:0] RST_BASE    = 16'hFFD0;
    localparam logic [15:0] SOF_MASK    = 16'hFFF0;
    localparam logic [15:0] SOF_BASE    = 16'hFFC0;
    localparam logic [7:0]  PRECISION   = 8'd8;

    localparam logic [INDEX_W-1:0] TAG_LEN   = 3'd5;
    localparam logic [INDEX_W-1:0] SOF_BYTES = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    image_height;
        logic [DIM_W-1:0]    image_width;
        logic                is_ycbcr;
    } result_t;

    // "JFIF" followed by nul
    function automatic logic [BYTE_W-1:0] jfif_tag(input logic [INDEX_W-1:0] idx);
        logic [BYTE_W-1:0] t;
        case (idx)
            3'd0:    t = 8'h4A;
            3'd1:    t = 8'h46;
            3'd2:    t = 8'h49;
            3'd3:    t = 8'h46;
            default: t = 8'h00;
        endcase
        return t;
    endfunction

    function automatic logic no_length(input logic [15:0] m);
        return ((m & RST_MASK) == RST_BASE) ||
               (m inside {MARKER_SOI, MARKER_EOI, MARKER_TEM});
    endfunction

    function automatic logic is_frame_marker(input logic [15:0] m);
        return ((m & SOF_MASK) == SOF_BASE) &&
               !(m inside {MARKER_DHT, MARKER_JPG, MARKER_DAC});
    endfunction

endpackage

// ===== src/jhs_in_reg.sv =====
// input register of the jfif header scanner
// depends on jhs_pkg for the item type
module jhs_in_reg
    import jhs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== src/jhs_parser.sv =====
// segment walker: parse state and next-state logic for one byte per cycle while advance is high
// depends on jhs_pkg for codes, types and marker helpers
module jhs_parser
    import jhs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     advance,
    input  in_item_t item,
    output logic     res_valid,
    output result_t  res
);

    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         mark_hi_reg, mark_hi_next;
    logic [15:0]        remain_reg, remain_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [SOF_W-1:0]   sof_reg, sof_next;
    logic               decided_reg, decided_next;

    always_comb begin
        logic [15:0] marker;
        logic [15:0] seg_len;
        logic [7:0]  b;
        logic [7:0]  prec;
        logic [7:0]  comps;
        logic        finish;

        stage_next   = stage_reg;
        phase_next   = phase_reg;
        mark_hi_next = mark_hi_reg;
        remain_next  = remain_reg;
        index_next   = index_reg;
        sof_next     = sof_reg;
        decided_next = decided_reg;
        res_valid    = 1'b0;
        res          = '0;
        finish       = 1'b0;
        prec         = '0;
        comps        = '0;
        b            = item.data_byte;
        marker       = {mark_hi_reg, b};
        seg_len      = {remain_reg[15:8], b};

        if (advance && !decided_reg) begin
            case (phase_reg)
                PH_MARK_HI: begin
                    mark_hi_next = b;
                    phase_next   = PH_MARK_LO;
                end
                PH_MARK_LO: begin
                    phase_next = PH_MARK_HI;
                    if (stage_reg == STAGE_SOI) begin
                        if (marker != MARKER_SOI) begin
                            decided_next = 1'b1;
                            res_valid    = 1'b1;
                            res.status   = STATUS_NO_SOI;
                        end else begin
                            stage_next = STAGE_APP0;
                        end
                    end else if (stage_reg == STAGE_APP0) begin
                        if (marker != MARKER_APP0) begin
                            decided_next = 1'b1;
                            res_valid    = 1'b1;
                            res.status   = STATUS_BAD_APP0;
                        end else begin
                            phase_next = PH_LEN_HI;
                        end
                    end else if (!no_length(marker)) begin
                        if (is_frame_marker(marker)) begin
                            stage_next = STAGE_SOF;
                            index_next = '0;
                            sof_next   = '0;
                        end
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    remain_next = {b, 8'h00};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (seg_len < 16'd2) begin
                        decided_next = 1'b1;
                        res_valid    = 1'b1;
                        res.status   = (stage_reg == STAGE_APP0) ? STATUS_BAD_APP0
                                                                 : STATUS_MALFORMED;
                    end else begin
                        remain_next = seg_len - 16'd2;
                        index_next  = '0;
                        if (stage_reg == STAGE_APP0 && remain_next < 16'd5) begin
                            decided_next = 1'b1;
                            res_valid    = 1'b1;
                            res.status   = STATUS_BAD_APP0;
                        end else if (remain_next == 16'd0) begin
                            if (stage_reg == STAGE_SOF) begin
                                finish = 1'b1;
                            end else begin
                                phase_next = PH_MARK_HI;
                            end
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    remain_next = remain_reg - 16'd1;
                    if (stage_reg == STAGE_APP0 && index_reg < TAG_LEN
                            && b != jfif_tag(index_reg)) begin
                        decided_next = 1'b1;
                        res_valid    = 1'b1;
                        res.status   = STATUS_BAD_APP0;
                    end else begin
                        if (stage_reg == STAGE_APP0 && index_reg < TAG_LEN) begin
                            index_next = index_reg + 3'd1;
                        end else if (stage_reg == STAGE_SOF && index_reg < SOF_BYTES) begin
                            // first sof byte ends up in the top bits after six shifts
                            sof_next   = {sof_reg[SOF_W-9:0], b};
                            index_next = index_reg + 3'd1;
                        end
                        if (remain_next == 16'd0) begin
                            if (stage_reg == STAGE_SOF) begin
                                finish = 1'b1;
                            end else begin
                                if (stage_reg == STAGE_APP0) begin
                                    stage_next = STAGE_SCAN;
                                end
                                phase_next = PH_MARK_HI;
                                index_next = '0;
                            end
                        end
                    end
                end
            endcase

            if (finish) begin
                prec         = sof_next[47:40];
                comps        = sof_next[7:0];
                decided_next = 1'b1;
                res_valid    = 1'b1;
                if (index_next < SOF_BYTES || prec != PRECISION
                        || !(comps inside {8'd1, 8'd3})) begin
                    res.status = STATUS_BAD_SOF;
                end else begin
                    res.status       = STATUS_OK;
                    res.image_height = sof_next[39:24];
                    res.image_width  = sof_next[23:8];
                    res.is_ycbcr     = (comps == 8'd3);
                end
            end
        end

        // truncated stream gets its verdict with the last byte
        if (advance && !decided_next && item.end_of_file) begin
            res_valid = 1'b1;
            res       = '0;
            case (stage_next)
                STAGE_SOI:  res.status = STATUS_NO_SOI;
                STAGE_APP0: res.status = STATUS_BAD_APP0;
                default:    res.status = STATUS_MALFORMED;
            endcase
        end
    end

    wire restart = advance && item.end_of_file;

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            stage_reg   <= STAGE_SOI;
            phase_reg   <= PH_MARK_HI;
            mark_hi_reg <= '0;
            remain_reg  <= '0;
            index_reg   <= '0;
            sof_reg     <= '0;
            decided_reg <= 1'b0;
        end else begin
            stage_reg   <= stage_next;
            phase_reg   <= phase_next;
            mark_hi_reg <= mark_hi_next;
            remain_reg  <= remain_next;
            index_reg   <= index_next;
            sof_reg     <= sof_next;
            decided_reg <= decided_next;
        end
    end

endmodule

// ===== src/jhs_out_reg.sv =====
// result register of the jfif header scanner
// depends on jhs_pkg for the result type
module jhs_out_reg
    import jhs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign room = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== src/jfif_header_scanner.sv =====
// jfif header scanner: walks the marker segments of a jpeg file, one byte per item
// depends on jhs_pkg, jhs_in_reg, jhs_parser and jhs_out_reg
//
// usage:
//   s_ channel: one file byte per item (s_data_byte), s_end_of_file high on the
//   final byte of the file. m_ channel: at most one result per file, giving
//   m_status, m_image_height, m_image_width and m_is_ycbcr; the size fields are
//   zero unless the status is ok.
//   a byte is registered on acceptance and parsed when it moves on from the input
//   register; the result, if any, is loaded into the output register, which drives
//   m_valid. bytes after the decision are dropped until the end-of-file byte,
//   which returns the parser to its start state.
//   throughput is one byte per cycle unless a result is held by a stalled receiver.
//   when the receiver stalls with a result held, at most one more byte is taken
//   into the input register and s_ready then drops until the result goes.
//   reset (aresetn low, synchronous) empties both registers and restarts parsing.
module jfif_header_scanner
    import jhs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [BYTE_W-1:0]   s_data_byte,
    input  logic                s_end_of_file,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [DIM_W-1:0]    m_image_height,
    output logic [DIM_W-1:0]    m_image_width,
    output logic                m_is_ycbcr
);

    in_item_t s_item, item;
    logic     item_valid, advance, room, res_valid;
    result_t  res, m_res;

    assign s_item.data_byte   = s_data_byte;
    assign s_item.end_of_file = s_end_of_file;

    // a byte moves on only when a result it might cause has a place to go
    assign advance = item_valid && room;

    jhs_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    jhs_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    jhs_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (res_valid),
        .res     (res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_status       = m_res.status;
    assign m_image_height = m_res.image_height;
    assign m_image_width  = m_res.image_width;
    assign m_is_ycbcr     = m_res.is_ycbcr;

endmodule

// ===== src/jhs_checker.sv =====
// port-level checks for the jfif header scanner, bound to the top level
// depends on jhs_pkg for the status codes
module jhs_checker
    import jhs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [STATUS_W-1:0] m_status,
    input logic [DIM_W-1:0]    m_image_height,
    input logic [DIM_W-1:0]    m_image_width,
    input logic                m_is_ycbcr
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_image_height) && $stable(m_image_width) && $stable(m_is_ycbcr))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= STATUS_BAD_SOF)
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |->
            m_image_height == '0 && m_image_width == '0 && !m_is_ycbcr)
        else $error("size fields set on a failed item");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

endmodule

bind jfif_header_scanner jhs_checker u_jhs_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_image_height (m_image_height),
    .m_image_width  (m_image_width),
    .m_is_ycbcr     (m_is_ycbcr)
);

// ===== dv/jfif_header_scanner_test.sv =====
// testbench for jfif_header_scanner: feeds jpeg byte streams, predicts the header verdict
// depends on jhs_pkg and the jfif_header_scanner rtl; stands alone otherwise
`timescale 1ns / 100ps

module jfif_header_scanner_test;
    import jhs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_BYTES = 300;
    localparam int MIN_FILES    = 12;
    localparam int CALM_FILES   = 5;
    localparam int IDLE_PCT     = 36;

    localparam logic [15:0] MARKER_DQT  = 16'hFFDB;
    localparam logic [15:0] MARKER_COM  = 16'hFFFE;
    localparam logic [7:0]  GRAY_COMPS  = 8'd1;
    localparam logic [7:0]  COLOR_COMPS = 8'd3;
    localparam logic [39:0] JFIF_ID     = 40'h4A_46_49_46_00;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_data_byte;
    logic                s_end_of_file;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [DIM_W-1:0]    m_image_height;
    logic [DIM_W-1:0]    m_image_width;
    logic                m_is_ycbcr;

    jfif_header_scanner dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_end_of_file  (s_end_of_file),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_image_height (m_image_height),
        .m_image_width  (m_image_width),
        .m_is_ycbcr     (m_is_ycbcr)
    );

    // predictor state
    logic [STAGE_W-1:0] hdr_stage;
    logic [PHASE_W-1:0] hdr_phase;
    logic [15:0]        seg_marker;
    logic [15:0]        seg_left;
    logic [INDEX_W-1:0] field_idx;
    logic [SOF_W-1:0]   frame_bytes;
    bit                 verdict_done;
    bit                 verdict_ready;
    result_t            verdict;

    result_t    pending_results[$];
    bit [7:0]   image_q[$];
    int         fault_count;
    int         parsed_bytes;
    int         cycles;
    bit         stall_req;
    bit         sender_calm;
    bit         sink_calm;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    task automatic clear_model();
        hdr_stage    = STAGE_SOI;
        hdr_phase    = PH_MARK_HI;
        seg_marker   = '0;
        seg_left     = '0;
        field_idx    = '0;
        frame_bytes  = '0;
        verdict_done = 1'b0;
    endtask

    task automatic conclude(input logic [STATUS_W-1:0] st);
        verdict_done  = 1'b1;
        verdict_ready = 1'b1;
        verdict       = '0;
        verdict.status = st;
    endtask

    task automatic close_frame();
        logic [7:0] comps;
        comps = frame_bytes[7:0];
        if (field_idx < SOF_BYTES || frame_bytes[47:40] != PRECISION ||
            !(comps == GRAY_COMPS || comps == COLOR_COMPS)) begin
            conclude(STATUS_BAD_SOF);
        end else begin
            conclude(STATUS_OK);
            verdict.image_height = frame_bytes[39:24];
            verdict.image_width  = frame_bytes[23:8];
            verdict.is_ycbcr     = (comps == COLOR_COMPS);
        end
    endtask

    task automatic scan_header_byte(input logic [7:0] b, input logic eof);
        logic tag_bad;
        verdict_ready = 1'b0;
        tag_bad = 1'b0;
        if (!verdict_done) begin
            parsed_bytes++;
            case (hdr_phase)
                PH_MARK_HI: begin
                    seg_marker = {b, 8'h00};
                    hdr_phase  = PH_MARK_LO;
                end
                PH_MARK_LO: begin
                    seg_marker[7:0] = b;
                    hdr_phase = PH_MARK_HI;
                    if (hdr_stage == STAGE_SOI) begin
                        if (seg_marker != MARKER_SOI) conclude(STATUS_NO_SOI);
                        else hdr_stage = STAGE_APP0;
                    end else if (hdr_stage == STAGE_APP0) begin
                        if (seg_marker != MARKER_APP0) conclude(STATUS_BAD_APP0);
                        else hdr_phase = PH_LEN_HI;
                    end else if (!((seg_marker & RST_MASK) == RST_BASE ||
                                   seg_marker == MARKER_SOI || seg_marker == MARKER_EOI ||
                                   seg_marker == MARKER_TEM)) begin
                        // first frame header that is not dht, jpg or dac
                        if ((seg_marker & SOF_MASK) == SOF_BASE && seg_marker != MARKER_DHT &&
                            seg_marker != MARKER_JPG && seg_marker != MARKER_DAC) begin
                            hdr_stage   = STAGE_SOF;
                            field_idx   = '0;
                            frame_bytes = '0;
                        end
                        hdr_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    seg_left  = {b, 8'h00};
                    hdr_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    seg_left[7:0] = b;
                    if (seg_left < 16'd2) begin
                        conclude(hdr_stage == STAGE_APP0 ? STATUS_BAD_APP0 : STATUS_MALFORMED);
                    end else begin
                        seg_left  = seg_left - 16'd2;
                        field_idx = '0;
                        if (hdr_stage == STAGE_APP0 && seg_left < TAG_LEN) begin
                            conclude(STATUS_BAD_APP0);
                        end else if (seg_left == 16'd0) begin
                            if (hdr_stage == STAGE_SOF) close_frame();
                            else hdr_phase = PH_MARK_HI;
                        end else begin
                            hdr_phase = PH_PAYLOAD;
                        end
                    end
                end
                default: begin
                    seg_left = seg_left - 16'd1;
                    if (hdr_stage == STAGE_APP0 && field_idx < TAG_LEN) begin
                        if (b != JFIF_ID[8*(4-field_idx) +: 8]) begin
                            tag_bad = 1'b1;
                            conclude(STATUS_BAD_APP0);
                        end else begin
                            field_idx++;
                        end
                    end else if (hdr_stage == STAGE_SOF && field_idx < SOF_BYTES) begin
                        frame_bytes[8*(5-field_idx) +: 8] = b;
                        field_idx++;
                    end
                    if (!tag_bad && seg_left == 16'd0) begin
                        if (hdr_stage == STAGE_SOF) begin
                            close_frame();
                        end else begin
                            if (hdr_stage == STAGE_APP0) hdr_stage = STAGE_SCAN;
                            hdr_phase = PH_MARK_HI;
                            field_idx = '0;
                        end
                    end
                end
            endcase
        end
        // stream cut short before any verdict
        if (!verdict_done && eof) begin
            conclude(hdr_stage == STAGE_SOI  ? STATUS_NO_SOI :
                     hdr_stage == STAGE_APP0 ? STATUS_BAD_APP0 : STATUS_MALFORMED);
        end
        if (verdict_ready) pending_results.push_back(verdict);
        if (eof) clear_model();
    endtask

    // ---------------------------------------------------------------- driving

    // called just after a falling edge, returns just after a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (!sender_calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_valid       = 1'b1;
        s_data_byte   = b;
        s_end_of_file = eof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_header_byte(b, eof);
        @(negedge aclk);
    endtask

    task automatic ship_file();
        for (int i = 0; i < image_q.size(); i++) send_byte(image_q[i], i == image_q.size() - 1);
        image_q.delete();
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                m_ready = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(negedge aclk);
                stall_req = 1'b0;
            end else begin
                m_ready = sink_calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge aclk) begin
        result_t seen;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen.status       = m_status;
            seen.image_height = m_image_height;
            seen.image_width  = m_image_width;
            seen.is_ycbcr     = m_is_ycbcr;
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: status %0d height %0d width %0d ycbcr %0b",
                             seen.status, seen.image_height, seen.image_width, seen.is_ycbcr);
            end else begin
                want = pending_results.pop_front();
                if (seen !== want) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: exp status %0d h %0d w %0d ycbcr %0b, got %0d %0d %0d %0b",
                                 want.status, want.image_height, want.image_width, want.is_ycbcr,
                                 seen.status, seen.image_height, seen.image_width, seen.is_ycbcr);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stream builders

    task automatic emit16(input logic [15:0] v);
        image_q.push_back(v[15:8]);
        image_q.push_back(v[7:0]);
    endtask

    task automatic emit_seg(input logic [15:0] m, input int n);
        emit16(m);
        emit16(16'(n + 2));
        repeat (n) image_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // soi plus an app0 segment with a valid tag and extra bytes of trailing payload
    task automatic emit_head(input int extra);
        emit16(MARKER_SOI);
        emit16(MARKER_APP0);
        emit16(16'(7 + extra));
        for (int i = 4; i >= 0; i--) image_q.push_back(JFIF_ID[8*i +: 8]);
        repeat (extra) image_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic emit_frame(input logic [15:0] m, input logic [7:0] prec,
                              input logic [15:0] h, input logic [15:0] w,
                              input logic [7:0] comps, input int n);
        logic [47:0] fixed;
        logic [7:0]  r;
        fixed = {prec, h, w, comps};
        emit16(m);
        emit16(16'(n + 2));
        for (int i = 0; i < n; i++) begin
            if (i < 6) r = fixed[8*(5-i) +: 8];
            else r = 8'($urandom_range(0, 255));
            image_q.push_back(r);
        end
    endtask

    function automatic logic [15:0] pick_dim();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'h0000;
        if (k == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic build_random_file();
        int          mode;
        logic [15:0] m;
        logic [7:0]  prec;
        logic [7:0]  comps;
        int          n;
        mode = $urandom_range(0, 99);
        if (mode < 8) begin
            // plain noise
            repeat ($urandom_range(1, 10)) image_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        emit_head($urandom_range(0, 3));
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
                0: begin
                    case ($urandom_range(0, 3))
                        0:       m = RST_BASE | 16'($urandom_range(0, 7));
                        1:       m = MARKER_SOI;
                        2:       m = MARKER_EOI;
                        default: m = MARKER_TEM;
                    endcase
                    emit16(m);
                end
                1: begin
                    case ($urandom_range(0, 2))
                        0:       m = MARKER_DHT;
                        1:       m = MARKER_JPG;
                        default: m = MARKER_DAC;
                    endcase
                    emit_seg(m, $urandom_range(0, 4));
                end
                2: emit_seg(MARKER_APP0 | 16'($urandom_range(0, 15)), $urandom_range(0, 4));
                default: emit_seg($urandom_range(0, 1) ? MARKER_DQT : MARKER_COM,
                                  $urandom_range(0, 4));
            endcase
        end
        do m = SOF_BASE | 16'($urandom_range(0, 15));
        while (m == MARKER_DHT || m == MARKER_JPG || m == MARKER_DAC);
        if ($urandom_range(0, 99) < 85) prec = PRECISION;
        else prec = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 80) comps = $urandom_range(0, 1) ? COLOR_COMPS : GRAY_COMPS;
        else comps = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 88) n = 6 + $urandom_range(0, 3);
        else n = $urandom_range(0, 5);
        emit_frame(m, prec, pick_dim(), pick_dim(), comps, n);
        repeat ($urandom_range(0, 4)) image_q.push_back(8'($urandom_range(0, 255)));
        if (mode >= 78 && mode < 92) begin
            // one byte overwritten anywhere in the stream
            image_q[$urandom_range(0, image_q.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (mode >= 92) begin
            repeat ($urandom_range(1, image_q.size() - 1)) void'(image_q.pop_back());
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_no_soi();
        image_q.push_back(8'hFF);
        ship_file();
        // wrong first marker, then a byte that is dropped
        emit16(MARKER_EOI);
        image_q.push_back(8'h00);
        ship_file();
        emit16(16'h0000);
        ship_file();
    endtask

    task automatic test_app0_checks();
        emit16(MARKER_SOI);
        emit16(MARKER_APP0 | 16'h0001);
        image_q.push_back(8'h00);
        ship_file();
        emit16(MARKER_SOI);
        emit16(MARKER_APP0);
        emit16(16'd6);
        ship_file();
        emit16(MARKER_SOI);
        emit16(MARKER_APP0);
        emit16(16'd1);
        ship_file();
        // tag breaks at its second byte
        emit16(MARKER_SOI);
        emit16(MARKER_APP0);
        emit16(16'd16);
        image_q.push_back(8'h4A);
        image_q.push_back(8'h47);
        image_q.push_back(8'h00);
        ship_file();
        emit16(MARKER_SOI);
        emit16(MARKER_APP0);
        image_q.push_back(8'h00);
        ship_file();
    endtask

    task automatic test_scan_rules();
        emit_head(2);
        emit16(RST_BASE | 16'h0007);
        emit16(MARKER_TEM);
        emit16(MARKER_EOI);
        emit16(MARKER_SOI);
        emit_seg(MARKER_DHT, 2);
        emit_seg(MARKER_JPG, 0);
        emit_seg(MARKER_DAC, 1);
        emit_seg(MARKER_APP0, 3);
        emit16(MARKER_DQT);
        emit16(16'd1);
        ship_file();
        emit_head(0);
        emit_seg(MARKER_COM, 5);
        ship_file();
    endtask

    task automatic test_frame_checks();
        emit_head(0);
        emit_frame(SOF_BASE, PRECISION, 16'd1, 16'd2, GRAY_COMPS, 4);
        ship_file();
        emit_head(1);
        emit_frame(SOF_BASE | 16'h0001, PRECISION, 16'd1, 16'd2, GRAY_COMPS, 0);
        ship_file();
        emit_head(0);
        emit_frame(SOF_BASE | 16'h0002, 8'd12, 16'd100, 16'd200, GRAY_COMPS, 6);
        ship_file();
        emit_head(0);
        emit_frame(SOF_BASE | 16'h0005, PRECISION, 16'd100, 16'd200, 8'd2, 6);
        ship_file();
        emit_head(0);
        emit_frame(SOF_BASE | 16'h0009, PRECISION, 16'd7, 16'd9, 8'hFF, 7);
        ship_file();
        // good header followed by bytes that must be dropped
        emit_head(3);
        emit_frame(SOF_BASE | 16'h000F, PRECISION, 16'hFFFF, 16'hFFFF, COLOR_COMPS, 9);
        emit16(MARKER_EOI);
        image_q.push_back(8'hFF);
        ship_file();
        emit_head(0);
        emit_frame(SOF_BASE | 16'h0003, PRECISION, 16'h0000, 16'h0000, GRAY_COMPS, 6);
        ship_file();
    endtask

    task automatic test_truncation();
        emit16(MARKER_SOI);
        ship_file();
        emit_head(0);
        emit_frame(SOF_BASE, PRECISION, 16'd640, 16'd480, COLOR_COMPS, 6);
        repeat (3) void'(image_q.pop_back());
        ship_file();
    endtask

    task automatic test_random_files();
        int files;
        files = 0;
        parsed_bytes = 0;
        while (parsed_bytes < RANDOM_BYTES || files < MIN_FILES) begin
            // opening stretch runs both sides flat out
            sender_calm = (files < CALM_FILES);
            sink_calm   = (files < CALM_FILES);
            build_random_file();
            ship_file();
            files++;
        end
        sender_calm = 1'b0;
        sink_calm   = 1'b0;
    endtask

    task automatic test_output_stall();
        stall_req = 1'b1;
        repeat (6) begin
            emit16(MARKER_SOI);
            emit16(MARKER_EOI);
            ship_file();
        end
        repeat (3) begin
            build_random_file();
            ship_file();
        end
        wait_drained();
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            build_random_file();
            ship_file();
            wait_drained();
            repeat ($urandom_range(5, 30)) @(negedge aclk);
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = '0;
        s_end_of_file = 1'b0;
        stall_req     = 1'b0;
        sender_calm   = 1'b0;
        sink_calm     = 1'b0;
        fault_count   = 0;
        parsed_bytes  = 0;
        verdict_ready = 1'b0;
        verdict       = '0;
        clear_model();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_no_soi();
        test_app0_checks();
        test_scan_rules();
        test_frame_checks();
        test_truncation();
        test_random_files();
        test_output_stall();
        test_drain_pause();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        fault_count += pending_results.size();
        if (fault_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
